FILE: rtl/ssra_pkg.sv
// Shared constants and types for the sorted sparse row accumulator.
// No dependencies; the interfaces and the top level import this package.
package ssra_pkg;

    localparam int CAPACITY      = 32;
    localparam int INDEX_BITS    = 16;
    localparam int COL_W         = 16;
    localparam int VAL_W         = 32;
    localparam int ENTRY_COUNT_W = 6;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] key;
        logic [VAL_W-1:0]      val;
    } entry_t;

endpackage

FILE: rtl/ssra_in_if.sv
// Input channel of the sorted sparse row accumulator: one add or drain word.
// Depends on ssra_pkg for the field widths.
interface ssra_in_if;
    import ssra_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] add_value;

    modport source (output valid, op, col_index, add_value, input ready);
    modport sink (input valid, op, col_index, add_value, output ready);

endinterface

FILE: rtl/ssra_out_if.sv
// Result channel of the sorted sparse row accumulator.
// Depends on ssra_pkg for the field widths.
interface ssra_out_if;
    import ssra_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         out_index;
    logic signed [VAL_W-1:0]  out_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last_flag;
    logic                     full_drop;
    logic                     sat_flag;
    logic                     empty_flag;

    modport source (output valid, out_index, out_value, entry_count, last_flag,
                    full_drop, sat_flag, empty_flag, input ready);
    modport sink (input valid, out_index, out_value, entry_count, last_flag,
                  full_drop, sat_flag, empty_flag, output ready);

endinterface

FILE: rtl/sorted_sparse_row_accumulator.sv
// Sorted sparse row accumulator top level: entry memory, sequencer, output register.
// Depends on ssra_pkg, ssra_in_if and ssra_out_if.
//
// Usage: words arrive on req (valid/ready). An add word (op = add) either sums
// its value, with saturation, into the entry of the same column index or
// inserts a new entry at its sorted place, or drops it when the row is full;
// it returns one word on rsp with the entry count and the full_drop / sat_flag
// bits. A drain word returns every entry in ascending index order, one word per
// cycle while rsp does not stall, the final one marked by last_flag, and
// empties the row; an empty row returns one word with empty_flag set.
// Timing: req.ready is high only while the sequencer is idle. An add scans the
// entry memory one entry per cycle (one registered read port), then shifts the
// entries above the insertion point up one per cycle; it then writes the sum or
// the new entry and loads the result register. A drain loads one word per
// cycle while the result register is free. The result register lets a new word
// be accepted while the last result is still waiting on rsp.
// Reset clears the entry count and the sequencer; memory contents are left
// as they are. When rsp stalls, the sequencer holds until the result register
// frees up; a drain pauses and resumes without losing entries.
module sorted_sparse_row_accumulator (
    input logic        clk,
    input logic        rst_n,
    ssra_in_if.sink    req,
    ssra_out_if.source rsp
);
    import ssra_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_INSERT = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } state_t;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [INDEX_BITS-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic                   full_reg, full_next;
    logic                   sat_reg, sat_next;
    logic                   empty_reg, empty_next;

    entry_t                 mem [CAPACITY];
    entry_t                 rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    entry_t                 wr_data;

    logic                     out_valid_reg;
    logic [COL_W-1:0]         out_index_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    logic                     out_last_reg;
    logic                     out_full_reg;
    logic                     out_sat_reg;
    logic                     out_empty_reg;

    logic                   out_free;
    logic                   out_load;
    logic [COL_W-1:0]       ld_index;
    logic [VAL_W-1:0]       ld_value;
    logic                   ld_last;

    logic [CNT_W-1:0]       ptr_inc;
    logic                   ptr_is_last;
    logic                   row_full;
    logic [VAL_W:0]         sum_wide;
    logic                   sum_ovf;
    logic [VAL_W-1:0]       sum_sat;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign ptr_inc     = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_is_last = (ptr_inc == count_reg);
    assign row_full    = (count_reg == CNT_W'(CAPACITY));

    // Saturating add of the stored value and the incoming value.
    assign sum_wide = {rd_data_reg.val[VAL_W-1], rd_data_reg.val}
                    + {val_reg[VAL_W-1], val_reg};
    assign sum_ovf  = sum_wide[VAL_W] ^ sum_wide[VAL_W-1];
    assign sum_sat  = sum_ovf ? (sum_wide[VAL_W] ? VAL_MIN : VAL_MAX)
                              : sum_wide[VAL_W-1:0];

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        full_next  = full_reg;
        sat_next   = sat_reg;
        empty_next = empty_reg;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data_reg;
        out_load   = 1'b0;
        ld_index   = '0;
        ld_value   = '0;
        ld_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                // Entry 0 is always being read so a scan or drain can start at once.
                rd_addr = '0;
                if (req.valid)
                begin
                    key_next   = req.col_index[INDEX_BITS-1:0];
                    val_next   = req.add_value;
                    full_next  = 1'b0;
                    sat_next   = 1'b0;
                    empty_next = 1'b0;
                    ptr_next   = '0;
                    pos_next   = '0;
                    if (req.op == OP_DRAIN)
                    begin
                        if (count_reg == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_data_reg.key == key_reg)
                begin
                    state_next = S_ACC;
                end
                else if (rd_data_reg.key > key_reg)
                begin
                    pos_next = ptr_reg;
                    if (row_full)
                    begin
                        full_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // Start moving entries up, beginning with the top one.
                        ptr_next   = ADDR_W'(count_reg);
                        rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                        state_next = S_SHIFT;
                    end
                end
                else if (ptr_is_last)
                begin
                    if (row_full)
                    begin
                        full_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pos_next   = ADDR_W'(count_reg);
                        state_next = S_INSERT;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                    rd_addr  = ptr_reg + ADDR_W'(1);
                end
            end

            S_ACC:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = '{key: rd_data_reg.key, val: sum_sat};
                sat_next   = sum_ovf;
                state_next = S_EMIT;
            end

            S_SHIFT:
            begin
                // Write the entry read last cycle one place up, read the next one down.
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg - ADDR_W'(1);
                if ((ptr_reg - ADDR_W'(1)) == pos_reg)
                begin
                    rd_addr    = '0;
                    state_next = S_INSERT;
                end
                else
                begin
                    rd_addr = ptr_reg - ADDR_W'(2);
                end
            end

            S_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = '{key: key_reg, val: val_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    ld_index = COL_W'(rd_data_reg.key);
                    ld_value = rd_data_reg.val;
                    ld_last  = ptr_is_last;
                    if (ptr_is_last)
                    begin
                        rd_addr    = '0;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                        rd_addr  = ptr_reg + ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        full_reg  <= full_next;
        sat_reg   <= sat_next;
        empty_reg <= empty_next;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The count still holds the pre-drain value while drained words are loaded.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= ld_index;
            out_value_reg <= ld_value;
            out_count_reg <= ENTRY_COUNT_W'(count_reg);
            out_last_reg  <= ld_last;
            out_full_reg  <= full_reg;
            out_sat_reg   <= sat_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_index   = out_index_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last_flag   = out_last_reg;
    assign rsp.full_drop   = out_full_reg;
    assign rsp.sat_flag    = out_sat_reg;
    assign rsp.empty_flag  = out_empty_reg;

    // The row never holds more entries than the memory has places.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A dropped insert is only reported when the row really is full.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && full_reg) |-> row_full)
        else $error("full_drop reported on a row with free places");

    // The shift pointer stays above the insertion point.
    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (pos_reg < ptr_reg))
        else $error("shift pointer at or below insertion point");

    // The final drained word leaves the row empty.
    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && out_load && ld_last) |=> (count_reg == '0))
        else $error("row not empty after drain");

endmodule

FILE: tb/sorted_sparse_row_accumulator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_sparse_row_accumulator: directed and random add/drain words
// against a behavioral model of the sorted row. Depends on ssra_pkg, ssra_in_if, ssra_out_if
// and the accumulator RTL.
module sorted_sparse_row_accumulator_tb;
    import ssra_pkg::*;

    localparam int     LONG_HOLD   = 300;
    localparam int     TAIL_CYCLES = CAPACITY * 2 + 16;
    localparam longint SUM_MAX     = 64'sd2147483647;
    localparam longint SUM_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic                    op;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } row_request_t;

    typedef struct packed {
        logic [COL_W-1:0]         index;
        logic signed [VAL_W-1:0]  value;
        logic [ENTRY_COUNT_W-1:0] count;
        logic                     last;
        logic                     full;
        logic                     sat;
        logic                     empty;
    } row_result_t;

    logic clk;
    logic rst_n;

    ssra_in_if  req_bus ();
    ssra_out_if rsp_bus ();

    sorted_sparse_row_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Behavioral copy of the sorted row.
    logic [INDEX_BITS-1:0]   row_key [CAPACITY];
    logic signed [VAL_W-1:0] row_val [CAPACITY];
    int                      row_used;

    row_request_t request_backlog [$];
    row_result_t  pending_responses [$];
    row_request_t current_word;
    logic         word_taken;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_requests;
    int stalls_served;
    int hold_left;

    int error_count;
    int items_queued;
    int words_taken;
    int results_checked;
    int drains_seen;
    int sums_clamped;
    int inserts_dropped;

    function automatic void accumulate_or_drain(row_request_t w);
        row_result_t           r;
        int                    pos;
        logic [INDEX_BITS-1:0] key;
        longint                sum;
        r = '0;
        if (w.op == OP_ADD)
        begin
            key = w.col[INDEX_BITS-1:0];
            pos = 0;
            while (pos < row_used && row_key[pos] < key)
                pos++;
            if (pos < row_used && row_key[pos] == key)
            begin
                sum = longint'(row_val[pos]) + longint'(w.val);
                if (sum > SUM_MAX)
                begin
                    sum = SUM_MAX;
                    r.sat = 1'b1;
                end
                else if (sum < SUM_MIN)
                begin
                    sum = SUM_MIN;
                    r.sat = 1'b1;
                end
                row_val[pos] = sum[VAL_W-1:0];
            end
            else if (row_used >= CAPACITY)
            begin
                r.full = 1'b1;
            end
            else
            begin
                for (int j = row_used; j > pos; j--)
                begin
                    row_key[j] = row_key[j-1];
                    row_val[j] = row_val[j-1];
                end
                row_key[pos] = key;
                row_val[pos] = w.val;
                row_used++;
            end
            r.count = ENTRY_COUNT_W'(row_used);
            r.last  = 1'b1;
            sums_clamped    += r.sat;
            inserts_dropped += r.full;
            pending_responses.push_back(r);
        end
        else
        begin
            drains_seen++;
            if (row_used == 0)
            begin
                r.last  = 1'b1;
                r.empty = 1'b1;
                pending_responses.push_back(r);
            end
            else
            begin
                for (int k = 0; k < row_used; k++)
                begin
                    r.index = row_key[k];
                    r.value = row_val[k];
                    r.count = ENTRY_COUNT_W'(row_used);
                    r.last  = (k == row_used - 1);
                    pending_responses.push_back(r);
                end
                row_used = 0;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_response();
        row_result_t want;
        if (pending_responses.size() == 0)
        begin
            $display("%0t: unexpected result word: expected none, actual index %0h value %0h",
                     $time, rsp_bus.out_index, rsp_bus.out_value);
            error_count++;
            return;
        end
        want = pending_responses.pop_front();
        results_checked++;
        check_field("out_index", 32'(want.index), 32'(rsp_bus.out_index));
        check_field("out_value", 32'(want.value), 32'(rsp_bus.out_value));
        check_field("entry_count", 32'(want.count), 32'(rsp_bus.entry_count));
        check_field("last_flag", 32'(want.last), 32'(rsp_bus.last_flag));
        check_field("full_drop", 32'(want.full), 32'(rsp_bus.full_drop));
        check_field("sat_flag", 32'(want.sat), 32'(rsp_bus.sat_flag));
        check_field("empty_flag", 32'(want.empty), 32'(rsp_bus.empty_flag));
    endfunction

    function automatic void queue_word(logic op, logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
        row_request_t w;
        w.op  = op;
        w.col = col;
        w.val = val;
        request_backlog.push_back(w);
        items_queued++;
    endfunction

    // Extremes show up often so that saturation in both directions is frequent.
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VAL_W'($urandom_range(2 * 65536)) - 32'd65536;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_row_sequence();
        logic [COL_W-1:0] pool [4];
        int               adds;
        bit               narrow;
        narrow = ($urandom_range(2) != 0);
        adds   = $urandom_range(12, 1);
        foreach (pool[i])
            pool[i] = COL_W'($urandom);
        if ($urandom_range(3) == 0)
            pool[0] = '0;
        if ($urandom_range(3) == 0)
            pool[1] = '1;
        for (int i = 0; i < adds; i++)
            queue_word(OP_ADD, narrow ? pool[2'($urandom_range(3))] : COL_W'($urandom),
                       random_value());
        // Leaving some rows undrained lets the next sequence start on a partly filled table.
        if ($urandom_range(9) != 0)
            queue_word(OP_DRAIN, COL_W'($urandom), $urandom);
    endfunction

    function automatic void queue_fill_sequence();
        logic [COL_W-1:0] first_key;
        first_key = COL_W'($urandom);
        queue_word(OP_DRAIN, COL_W'($urandom), $urandom);
        queue_word(OP_ADD, first_key, random_value());
        for (int i = 1; i < CAPACITY + 3; i++)
            queue_word(OP_ADD, COL_W'($urandom), random_value());
        // A matching index still accumulates once the table is full.
        queue_word(OP_ADD, first_key, random_value());
        queue_word(OP_DRAIN, COL_W'($urandom), $urandom);
    endfunction

    function automatic void queue_random_sequence();
        case ($urandom_range(19))
            0: queue_fill_sequence();
            1, 2: queue_word(OP_DRAIN, COL_W'($urandom), $urandom);
            3: queue_word(OP_ADD, COL_W'($urandom), random_value());
            default: queue_row_sequence();
        endcase
    endfunction

    function automatic void queue_directed();
        queue_word(OP_DRAIN, 16'h0000, 32'h0000_0000);
        queue_word(OP_ADD, 16'h8000, 32'h7FFF_FFFF);
        queue_word(OP_ADD, 16'h8000, 32'h0000_0001);
        queue_word(OP_ADD, 16'hFFFF, 32'h8000_0000);
        queue_word(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        queue_word(OP_ADD, 16'h0000, 32'h0001_0000);
        queue_word(OP_ADD, 16'h1234, 32'hFFFE_8000);
        queue_word(OP_ADD, 16'h0000, 32'hFFFF_0000);
        queue_word(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF);
        queue_word(OP_DRAIN, 16'hFFFF, 32'hFFFF_FFFF);
        queue_word(OP_DRAIN, 16'h0000, 32'h0000_0000);
        queue_word(OP_ADD, 16'h5555, 32'h5555_5555);
        queue_word(OP_ADD, 16'hAAAA, 32'hAAAA_AAAA);
        queue_word(OP_ADD, 16'h5555, 32'hAAAA_AAAA);
        queue_word(OP_DRAIN, 16'hAAAA, 32'h5555_5555);
    endfunction

    task automatic wait_backlog_sent();
        while (request_backlog.size() != 0 || req_bus.valid)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: holds a word until it is taken, otherwise offers the next one or idles.
    always @(negedge clk)
    begin
        logic offer;
        if (!rst_n)
            offer = 1'b0;
        else if (req_bus.valid && !word_taken)
            offer = 1'b1;
        else if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            current_word = request_backlog.pop_front();
            offer = 1'b1;
        end
        else
            offer = 1'b0;
        req_bus.valid     <= offer;
        req_bus.op        <= current_word.op;
        req_bus.col_index <= current_word.col;
        req_bus.add_value <= current_word.val;
    end

    // Result acceptor, with a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end
        else if (stalls_served != stall_requests)
        begin
            stalls_served++;
            hold_left = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                word_taken = 1'b1;
                words_taken++;
                accumulate_or_drain('{req_bus.op, req_bus.col_index, req_bus.add_value});
            end
            if (rsp_bus.valid && rsp_bus.ready)
                check_response();
        end
    end

    initial
    begin
        int waited;
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.op        = OP_ADD;
        req_bus.col_index = '0;
        req_bus.add_value = '0;
        rsp_bus.ready     = 1'b0;
        current_word      = '0;
        word_taken        = 1'b0;
        row_used          = 0;
        stall_requests    = 0;
        stalls_served     = 0;
        hold_left         = 0;
        error_count       = 0;
        items_queued      = 0;
        words_taken       = 0;
        results_checked   = 0;
        drains_seen       = 0;
        sums_clamped      = 0;
        inserts_dropped   = 0;
        send_idle_pct     = 28;
        recv_idle_pct     = 72;

        queue_directed();
        queue_fill_sequence();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        // Block the result side for a long hold-off as soon as reset is released.
        stall_requests++;
        while (items_queued < 80)
            queue_random_sequence();
        wait_backlog_sent();

        send_idle_pct = 72;
        recv_idle_pct = 28;
        while (items_queued < 145)
            queue_random_sequence();
        wait_backlog_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_fill_sequence();
        while (items_queued < 215)
            queue_random_sequence();
        wait_backlog_sent();

        waited = 0;
        while (pending_responses.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time,
                     pending_responses.size());
            error_count++;
        end

        $display("Sent %0d add/drain words and checked %0d result words (%0d drains).",
                 words_taken, results_checked, drains_seen);
        $display("Saturated sums: %0d, inserts dropped on a full row: %0d, mismatches: %0d.",
                 sums_clamped, inserts_dropped, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ssra_pkg.sv
rtl/ssra_in_if.sv
rtl/ssra_out_if.sv
rtl/sorted_sparse_row_accumulator.sv
tb/sorted_sparse_row_accumulator_tb.sv
